// ===== rtl/core/spt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the sorted pair table: field widths, table
// capacity, opcodes, result status codes, sequencer states, memory port types.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 64;
  localparam int ST_W     = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_MATCH    = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SWAIT,
    S_SHIFT,
    S_SHWR,
    S_LREAD,
    S_LCHK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/spt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_in_if / spt_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface spt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [spt_pkg::KEY_W-1:0] key;
  logic [spt_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface spt_out_if;
  logic                      valid;
  logic                      ready;
  logic [spt_pkg::VAL_W-1:0] found_value;
  logic [spt_pkg::ST_W-1:0]  status;
  logic                      last;

  modport source (output valid, output found_value, output status, output last,
                  input ready);
  modport sink   (input valid, input found_value, input status, input last,
                  output ready);
endinterface

// ===== rtl/core/sorted_pair_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_pair_table_unit
// Sorted (key, value) table with binary-search insert and multi-beat lookup.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and is not ready until the last
// result beat of that request sits in the output register. Every step goes
// through the entry memory (the sequencer issues one read or write per cycle,
// read data registered), so each binary-search probe is a read of the middle
// entry followed by a compare, and the search ends when the range is closed.
// After accepting a request, an insert searches, then moves each entry above
// the insert point up by one (a read, then a write), writes the new pair and
// returns its beat. A lookup searches, then reads and checks each matching
// entry, ends the run with a check that finds no further match (or the end
// of the table) and sends the final beat; it returns one beat per match (last
// set on the final one) or a single no-match beat. A full table rejects an
// insert without a search. Output back-pressure can stall result beats. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_pair_table_unit (
  input  logic clk_i,
  input  logic rst_ni,
  spt_in_if.sink    in_i,
  spt_out_if.source out_o
);
  import spt_pkg::*;

  state_e           state_q, state_d;
  logic             op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [VAL_W-1:0] pend_val_q, pend_val_d;
  status_e          st_q, st_d;

  logic             ov_q, ov_d;
  logic [VAL_W-1:0] o_val_q, o_val_d;
  status_e          o_st_q, o_st_d;
  logic             o_last_q, o_last_d;

  mem_req_t         mem_req;
  entry_t           rd_data;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] idx_m1;
  logic             below;
  logic             emit_free;

  spt_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // compare unit and index arithmetic
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CNT_W:1];
  assign idx_m1    = idx_q - CNT_W'(1);
  assign below     = (rd_data.key < key_q) ||
                     ((rd_data.key == key_q) && (rd_data.value < val_q));
  assign emit_free = !ov_q || out_o.ready;

  assign in_i.ready = (state_q == S_IDLE);

  // sequencer: next state, memory requests and result beats
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    cnt_d      = cnt_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_val_d = pend_val_q;
    st_d       = st_q;
    ov_d       = ov_q && !out_o.ready;
    o_val_d    = o_val_q;
    o_st_d     = o_st_q;
    o_last_d   = o_last_q;

    mem_req       = '0;
    mem_req.wdata = rd_data;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d   = in_i.opcode;
          key_d  = in_i.key;
          val_d  = (in_i.opcode == OP_LOOKUP) ? '0 : in_i.value;
          lo_d   = '0;
          hi_d   = cnt_q;
          pend_d = 1'b0;
          if ((in_i.opcode == OP_INSERT) && (cnt_q >= CNT_W'(CAPACITY))) begin
            st_d    = ST_FULL;
            state_d = S_FIN;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end

      // one binary-search probe: read the middle entry, or end the search once the range is closed
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = mid[IDX_W-1:0];
          state_d       = S_SWAIT;
        end else if (op_q == OP_INSERT) begin
          idx_d   = cnt_q;
          state_d = S_SHIFT;
        end else begin
          idx_d   = lo_q;
          state_d = S_LREAD;
        end
      end

      S_SWAIT: begin
        if (below) begin
          lo_d = mid + CNT_W'(1);
        end else begin
          hi_d = mid;
        end
        state_d = S_SEARCH;
      end

      // move entries above the insert point up, top first, then write the new pair
      S_SHIFT: begin
        if (idx_q > lo_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_m1[IDX_W-1:0];
          state_d       = S_SHWR;
        end else begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = lo_q[IDX_W-1:0];
          mem_req.wdata.key   = key_q;
          mem_req.wdata.value = val_q;
          cnt_d               = cnt_q + CNT_W'(1);
          st_d                = ST_INSERTED;
          state_d             = S_FIN;
        end
      end

      S_SHWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q[IDX_W-1:0];
        idx_d         = idx_m1;
        state_d       = S_SHIFT;
      end

      // lookup walk: one match is held back to know whether it is the last
      S_LREAD: begin
        if (idx_q < cnt_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q[IDX_W-1:0];
          state_d       = S_LCHK;
        end else begin
          st_d    = ST_NONE;
          state_d = S_FIN;
        end
      end

      S_LCHK: begin
        if (rd_data.key != key_q) begin
          st_d    = ST_NONE;
          state_d = S_FIN;
        end else if (!pend_q) begin
          pend_d     = 1'b1;
          pend_val_d = rd_data.value;
          idx_d      = idx_q + CNT_W'(1);
          state_d    = S_LREAD;
        end else if (emit_free) begin
          ov_d       = 1'b1;
          o_val_d    = pend_val_q;
          o_st_d     = ST_MATCH;
          o_last_d   = 1'b0;
          pend_val_d = rd_data.value;
          idx_d      = idx_q + CNT_W'(1);
          state_d    = S_LREAD;
        end
      end

      // final beat of the request
      S_FIN: begin
        if (emit_free) begin
          ov_d     = 1'b1;
          o_last_d = 1'b1;
          if (pend_q) begin
            o_val_d = pend_val_q;
            o_st_d  = ST_MATCH;
          end else begin
            o_val_d = '0;
            o_st_d  = st_q;
          end
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    pend_val_q <= pend_val_d;
    st_q       <= st_d;
    o_val_q    <= o_val_d;
    o_st_q     <= o_st_d;
    o_last_q   <= o_last_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.found_value = o_val_q;
  assign out_o.status      = o_st_q;
  assign out_o.last        = o_last_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready while a request is in progress");

  a_single_beat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_MATCH)) |-> out_o.last)
    else $error("non-match beat without last");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && st_q == ST_FULL) |-> (cnt_q == CNT_W'(CAPACITY)))
    else $error("full status with room left");

endmodule

// ===== rtl/core/spt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spt_store (
  input  logic              clk_i,
  input  spt_pkg::mem_req_t req_i,
  output spt_pkg::entry_t   rd_data_o
);
  import spt_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule
